>>> hdl/hbd_pkg.sv
// Package for the tree-walk symbol decoder: field widths, default
// parameters, function codes and the index wrap helper.
// No dependencies.
package hbd_pkg;

  localparam int unsigned NODE_COUNT_DEF   = 512;
  localparam int unsigned SYMBOL_WIDTH_DEF = 8;
  localparam int unsigned PORT_IDX_W       = 9;
  localparam int unsigned PORT_SYM_W       = 8;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef struct packed {
    logic vld;
    logic full;
  } hbd_q_stat_t;

  // Port index modulo n, by conditional subtraction of n shifted left by decreasing amounts.
  function automatic logic [PORT_IDX_W-1:0] wrap_index(input logic [PORT_IDX_W-1:0] v,
                                                       input int unsigned n);
    logic [21:0] r;
    logic [21:0] m;
    r = 22'(v);
    for (int k = PORT_IDX_W; k >= 0; k--) begin
      m = 22'(n) << k;
      if (r >= m) begin
        r = r - m;
      end
    end
    return r[PORT_IDX_W-1:0];
  endfunction

endpackage

>>> hdl/hbd_ram.sv
// Generic single-port RAM, registered read.
// No dependencies.
module hbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/hbd_front.sv
// Front end: accepts input items, wraps indexes, trims symbols and
// queues commands for the back end. Depends on hbd_pkg.
module hbd_front
  import hbd_pkg::*;
#(
  parameter int unsigned NODE_COUNT   = NODE_COUNT_DEF,
  parameter int unsigned SYMBOL_WIDTH = SYMBOL_WIDTH_DEF,
  localparam int unsigned IW    = $clog2(NODE_COUNT),
  localparam int unsigned NW    = 1 + SYMBOL_WIDTH + 2 * IW,
  localparam int unsigned CMD_W = 2 + IW + NW
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_func,
  input  logic [PORT_IDX_W-1:0] in_node_index,
  input  logic                  in_node_leaf,
  input  logic [PORT_SYM_W-1:0] in_node_symbol,
  input  logic [PORT_IDX_W-1:0] in_left_child,
  input  logic [PORT_IDX_W-1:0] in_right_child,
  input  logic                  in_code_bit,
  output logic [CMD_W-1:0]      cmd,
  output hbd_q_stat_t           q_stat,
  input  logic                  cmd_pop
);

  localparam int unsigned QD = 2;
  localparam int unsigned EW = (SYMBOL_WIDTH > PORT_SYM_W) ? SYMBOL_WIDTH : PORT_SYM_W;

  logic [CMD_W-1:0] qbuf_r [QD];
  logic             wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             acc;
  logic [EW-1:0]    sym_ext;
  logic [IW-1:0]    idx_w, left_w, right_w;
  logic [CMD_W-1:0] cmd_in;

  always_comb begin
    sym_ext = EW'(in_node_symbol);
    idx_w   = IW'(wrap_index(in_node_index, NODE_COUNT));
    left_w  = IW'(wrap_index(in_left_child, NODE_COUNT));
    right_w = IW'(wrap_index(in_right_child, NODE_COUNT));
    cmd_in  = {in_func == FUNC_DECODE, in_code_bit, idx_w,
               in_node_leaf, sym_ext[SYMBOL_WIDTH-1:0], left_w, right_w};
  end

  assign in_full     = (cnt_r == 2'(QD));
  assign acc         = in_push && !in_full;
  assign q_stat.vld  = (cnt_r != 2'd0);
  assign q_stat.full = in_full;
  assign cmd         = qbuf_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (acc) begin
      wp_nxt = ~wp_r;
    end
    if (cmd_pop) begin
      rp_nxt = ~rp_r;
    end
    priority if (acc && !cmd_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!acc && cmd_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      qbuf_r[wp_r] <= cmd_in;
    end
  end

endmodule

>>> hdl/hbd_back.sv
// Back end: node table, walk sequencer with cached current and root
// nodes, and the result queue. Depends on hbd_pkg and hbd_ram.
module hbd_back
  import hbd_pkg::*;
#(
  parameter int unsigned NODE_COUNT   = NODE_COUNT_DEF,
  parameter int unsigned SYMBOL_WIDTH = SYMBOL_WIDTH_DEF,
  localparam int unsigned IW    = $clog2(NODE_COUNT),
  localparam int unsigned NW    = 1 + SYMBOL_WIDTH + 2 * IW,
  localparam int unsigned CMD_W = 2 + IW + NW
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [CMD_W-1:0]      cmd,
  input  hbd_q_stat_t           q_stat,
  output logic                  cmd_pop,
  input  logic                  cfg_wr_en,
  input  logic [PORT_IDX_W-1:0] cfg_wr_data,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [PORT_SYM_W-1:0] out_symbol
);

  localparam int unsigned OQD = 2;
  localparam int unsigned EW  = (SYMBOL_WIDTH > PORT_SYM_W) ? SYMBOL_WIDTH : PORT_SYM_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FILL = 3'b010,
    ST_NEXT = 3'b100
  } bk_state_t;

  bk_state_t state_r, state_nxt;
  logic [IW-1:0] root_r, root_nxt, walk_r, walk_nxt, dest_r, dest_nxt;
  logic [NW-1:0] cur_r, cur_nxt, rnode_r, rnode_nxt;
  logic          cur_vld_r, cur_vld_nxt, rnode_vld_r, rnode_vld_nxt;

  logic [PORT_SYM_W-1:0] obuf_r [OQD];
  logic                  owp_r, owp_nxt, orp_r, orp_nxt;
  logic [1:0]            ocnt_r, ocnt_nxt;
  logic                  opush, oacc;
  logic [NW-1:0]         opush_node;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_addr;
  logic [NW-1:0] ram_rdata;

  logic          c_dec, c_bit;
  logic [IW-1:0] c_idx;
  logic [NW-1:0] c_node;
  logic [IW-1:0] c_dest;
  logic [EW-1:0] sym_ext;

  assign c_dec  = cmd[CMD_W-1];
  assign c_bit  = cmd[CMD_W-2];
  assign c_idx  = cmd[NW +: IW];
  assign c_node = cmd[NW-1:0];
  assign c_dest = c_bit ? cur_r[0 +: IW] : cur_r[IW +: IW];

  hbd_ram #(
    .WIDTH (NW),
    .DEPTH (NODE_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (c_node),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    root_nxt      = root_r;
    walk_nxt      = walk_r;
    dest_nxt      = dest_r;
    cur_nxt       = cur_r;
    cur_vld_nxt   = cur_vld_r;
    rnode_nxt     = rnode_r;
    rnode_vld_nxt = rnode_vld_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_addr      = walk_r;
    cmd_pop       = 1'b0;
    opush         = 1'b0;
    opush_node    = cur_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_stat.vld) begin
          if (!c_dec) begin
            ram_we   = 1'b1;
            ram_addr = c_idx;
            cmd_pop  = 1'b1;
            walk_nxt = root_r;
            if (c_idx == root_r) begin
              rnode_nxt     = c_node;
              rnode_vld_nxt = 1'b1;
              cur_nxt       = c_node;
              cur_vld_nxt   = 1'b1;
            end else begin
              cur_nxt     = rnode_r;
              cur_vld_nxt = rnode_vld_r;
            end
          end else if (ocnt_r != 2'(OQD)) begin
            if (!cur_vld_r) begin
              // root node not cached yet
              ram_re    = 1'b1;
              state_nxt = ST_FILL;
            end else if (cur_r[NW-1]) begin
              opush       = 1'b1;
              cmd_pop     = 1'b1;
              walk_nxt    = root_r;
              cur_nxt     = rnode_r;
              cur_vld_nxt = rnode_vld_r;
            end else begin
              ram_re    = 1'b1;
              ram_addr  = c_dest;
              dest_nxt  = c_dest;
              cmd_pop   = 1'b1;
              state_nxt = ST_NEXT;
            end
          end
        end
      end
      ST_FILL: begin
        cur_nxt       = ram_rdata;
        cur_vld_nxt   = 1'b1;
        rnode_nxt     = ram_rdata;
        rnode_vld_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_NEXT: begin
        if (ram_rdata[NW-1]) begin
          opush       = 1'b1;
          opush_node  = ram_rdata;
          walk_nxt    = root_r;
          cur_nxt     = rnode_r;
          cur_vld_nxt = rnode_vld_r;
        end else begin
          walk_nxt    = dest_r;
          cur_nxt     = ram_rdata;
          cur_vld_nxt = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // the user must write the root only while idle; the block does not enforce it
    if (cfg_wr_en) begin
      root_nxt      = IW'(wrap_index(cfg_wr_data, NODE_COUNT));
      walk_nxt      = root_nxt;
      cur_vld_nxt   = 1'b0;
      rnode_vld_nxt = 1'b0;
    end
  end

  assign sym_ext = EW'(opush_node[2*IW +: SYMBOL_WIDTH]);

  // result queue
  assign out_empty  = (ocnt_r == 2'd0);
  assign out_symbol = obuf_r[orp_r];
  assign oacc       = out_pop && !out_empty;

  always_comb begin
    owp_nxt  = owp_r;
    orp_nxt  = orp_r;
    ocnt_nxt = ocnt_r;
    if (opush) begin
      owp_nxt = ~owp_r;
    end
    if (oacc) begin
      orp_nxt = ~orp_r;
    end
    priority if (opush && !oacc) begin
      ocnt_nxt = ocnt_r + 2'd1;
    end else if (!opush && oacc) begin
      ocnt_nxt = ocnt_r - 2'd1;
    end else begin
      ocnt_nxt = ocnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      root_r      <= '0;
      walk_r      <= '0;
      cur_vld_r   <= 1'b0;
      rnode_vld_r <= 1'b0;
      owp_r       <= 1'b0;
      orp_r       <= 1'b0;
      ocnt_r      <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      root_r      <= root_nxt;
      walk_r      <= walk_nxt;
      cur_vld_r   <= cur_vld_nxt;
      rnode_vld_r <= rnode_vld_nxt;
      owp_r       <= owp_nxt;
      orp_r       <= orp_nxt;
      ocnt_r      <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dest_r  <= dest_nxt;
    cur_r   <= cur_nxt;
    rnode_r <= rnode_nxt;
    if (opush) begin
      obuf_r[owp_r] <= sym_ext[PORT_SYM_W-1:0];
    end
  end

endmodule

>>> hdl/huffman_tree_bit_decoder_core.sv
// Top level of the tree-walk symbol decoder: front end, command queue
// and back end. Depends on hbd_pkg, hbd_front, hbd_back.
//
//   channel  direction  handshake            transfer when
//   in_*     input      in_push / in_full    in_push && !in_full
//   out_*    output     out_empty / out_pop  out_pop && !out_empty
//   cfg_*    input      cfg_wr_en            cfg_wr_en
//
// In the back end a decode bit passes the idle and next states for the
// registered read of the child node from the single-port node table, or
// only idle when the walk stands on a leaf and no read is needed. After
// reset or a root write the first decode bit also reads the root node in
// the fill state. Reset is synchronous; the table is not cleared. A 2-entry
// command queue and a 2-entry result queue let either side stall.
module huffman_tree_bit_decoder_core
  import hbd_pkg::*;
#(
  parameter int unsigned NODE_COUNT   = NODE_COUNT_DEF,
  parameter int unsigned SYMBOL_WIDTH = SYMBOL_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_func,
  input  logic [PORT_IDX_W-1:0] in_node_index,
  input  logic                  in_node_leaf,
  input  logic [PORT_SYM_W-1:0] in_node_symbol,
  input  logic [PORT_IDX_W-1:0] in_left_child,
  input  logic [PORT_IDX_W-1:0] in_right_child,
  input  logic                  in_code_bit,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [PORT_SYM_W-1:0] out_symbol,
  input  logic                  cfg_wr_en,
  input  logic [PORT_IDX_W-1:0] cfg_wr_data
);

  localparam int unsigned IW    = $clog2(NODE_COUNT);
  localparam int unsigned NW    = 1 + SYMBOL_WIDTH + 2 * IW;
  localparam int unsigned CMD_W = 2 + IW + NW;

  logic [CMD_W-1:0] cmd;
  hbd_q_stat_t      q_stat;
  logic             cmd_pop;

  hbd_front #(
    .NODE_COUNT   (NODE_COUNT),
    .SYMBOL_WIDTH (SYMBOL_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_func        (in_func),
    .in_node_index  (in_node_index),
    .in_node_leaf   (in_node_leaf),
    .in_node_symbol (in_node_symbol),
    .in_left_child  (in_left_child),
    .in_right_child (in_right_child),
    .in_code_bit    (in_code_bit),
    .cmd            (cmd),
    .q_stat         (q_stat),
    .cmd_pop        (cmd_pop)
  );

  hbd_back #(
    .NODE_COUNT   (NODE_COUNT),
    .SYMBOL_WIDTH (SYMBOL_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .q_stat      (q_stat),
    .cmd_pop     (cmd_pop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_symbol  (out_symbol)
  );

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> q_stat.vld)
    else $error("input side full with no queued command");

  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> q_stat.vld)
    else $error("accepted item missing from command queue");

  a_no_pop_on_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !q_stat.vld |-> !cmd_pop)
    else $error("command popped from empty queue");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("waiting result lost");

endmodule

>>> tb/tb_huffman_tree_bit_decoder_core.sv
// Testbench for huffman_tree_bit_decoder_core: builds code trees, decodes random
// bit streams and checks every decoded symbol against an in-bench tree walk.
// Depends on hbd_pkg and the decoder RTL.
module tb_huffman_tree_bit_decoder_core;
  import hbd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TABLE_SIZE  = 512;

  typedef struct packed {
    logic                  func;
    logic [PORT_IDX_W-1:0] node_index;
    logic                  leaf;
    logic [PORT_SYM_W-1:0] sym;
    logic [PORT_IDX_W-1:0] left;
    logic [PORT_IDX_W-1:0] right;
    logic                  code_bit;
  } tree_cmd_t;

  typedef struct packed {
    logic                  leaf;
    logic [PORT_SYM_W-1:0] sym;
    logic [PORT_IDX_W-1:0] left;
    logic [PORT_IDX_W-1:0] right;
  } tree_node_t;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_push        = 1'b0;
  logic                  in_full;
  logic                  in_func        = FUNC_LOAD;
  logic [PORT_IDX_W-1:0] in_node_index  = '0;
  logic                  in_node_leaf   = 1'b0;
  logic [PORT_SYM_W-1:0] in_node_symbol = '0;
  logic [PORT_IDX_W-1:0] in_left_child  = '0;
  logic [PORT_IDX_W-1:0] in_right_child = '0;
  logic                  in_code_bit    = 1'b0;
  logic                  out_empty;
  logic                  out_pop        = 1'b0;
  logic [PORT_SYM_W-1:0] out_symbol;
  logic                  cfg_wr_en      = 1'b0;
  logic [PORT_IDX_W-1:0] cfg_wr_data    = '0;

  // decode walk state
  tree_node_t            node_mem [TABLE_SIZE];
  logic [PORT_IDX_W-1:0] walk_pos = '0;
  logic [PORT_IDX_W-1:0] root_reg = '0;
  logic [PORT_SYM_W-1:0] due_symbols [$];

  // stimulus bookkeeping
  tree_cmd_t             pending_cmds [$];
  tree_cmd_t             drv_cmd;
  logic                  drv_busy;
  bit                    gen_written [TABLE_SIZE];
  int unsigned           written_list [$];
  logic [PORT_IDX_W-1:0] gen_root = '0;
  int                    gen_items = 0;

  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          phase_no = 0;
  int          err_count = 0;
  int          rx_got = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          cycle_no = 0;
  logic [PORT_SYM_W-1:0] exp_sym;

  huffman_tree_bit_decoder_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_func        (in_func),
    .in_node_index  (in_node_index),
    .in_node_leaf   (in_node_leaf),
    .in_node_symbol (in_node_symbol),
    .in_left_child  (in_left_child),
    .in_right_child (in_right_child),
    .in_code_bit    (in_code_bit),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_symbol     (out_symbol),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_no++;
    if (cycle_no >= CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // One accepted command through the tree walk.
  function automatic void decode_walk(input tree_cmd_t c);
    tree_node_t            cur;
    tree_node_t            nxt;
    logic [PORT_IDX_W-1:0] dest;
    if (c.func == FUNC_LOAD) begin
      node_mem[c.node_index] = '{c.leaf, c.sym, c.left, c.right};
      walk_pos = root_reg;
    end else begin
      cur = node_mem[walk_pos];
      if (cur.leaf) begin
        due_symbols.push_back(cur.sym);
        walk_pos = root_reg;
      end else begin
        dest = c.code_bit ? cur.right : cur.left;
        nxt = node_mem[dest];
        if (nxt.leaf) begin
          due_symbols.push_back(nxt.sym);
          walk_pos = root_reg;
        end else begin
          walk_pos = dest;
        end
      end
    end
  endfunction

  function automatic tree_cmd_t rand_cmd();
    tree_cmd_t c;
    c.func       = 1'($urandom_range(1));
    c.node_index = PORT_IDX_W'($urandom_range(TABLE_SIZE - 1));
    c.leaf       = 1'($urandom_range(1));
    c.sym        = PORT_SYM_W'($urandom_range(255));
    c.left       = PORT_IDX_W'($urandom_range(TABLE_SIZE - 1));
    c.right      = PORT_IDX_W'($urandom_range(TABLE_SIZE - 1));
    c.code_bit   = 1'($urandom_range(1));
    return c;
  endfunction

  function automatic void push_load(input int unsigned idx, input bit leaf,
                                    input int unsigned sym, input int unsigned l,
                                    input int unsigned r);
    tree_cmd_t c;
    c = rand_cmd();
    c.func       = FUNC_LOAD;
    c.node_index = PORT_IDX_W'(idx);
    c.leaf       = leaf;
    c.sym        = PORT_SYM_W'(sym);
    c.left       = PORT_IDX_W'(l);
    c.right      = PORT_IDX_W'(r);
    pending_cmds.push_back(c);
    gen_items++;
    if (!gen_written[idx]) begin
      gen_written[idx] = 1'b1;
      written_list.push_back(idx);
    end
  endfunction

  function automatic void push_bit(input bit b);
    tree_cmd_t c;
    c = rand_cmd();
    c.func     = FUNC_DECODE;
    c.code_bit = b;
    pending_cmds.push_back(c);
    gen_items++;
  endfunction

  // Random full tree rooted at gen_root, loaded children first so that every
  // inner node already written only points at written nodes.
  function automatic void build_tree(input int leaves);
    bit                    is_leaf [128];
    int                    lc [128];
    int                    rc [128];
    int unsigned           slot [128];
    bit                    taken [TABLE_SIZE];
    int                    n_nodes;
    int                    pick;
    int unsigned           s;
    n_nodes = 1;
    is_leaf[0] = 1'b1;
    repeat (leaves - 1) begin
      do pick = $urandom_range(n_nodes - 1); while (!is_leaf[pick]);
      is_leaf[pick] = 1'b0;
      lc[pick] = n_nodes;
      rc[pick] = n_nodes + 1;
      is_leaf[n_nodes] = 1'b1;
      is_leaf[n_nodes + 1] = 1'b1;
      n_nodes += 2;
    end
    taken = '{default: 1'b0};
    slot[0] = 32'(gen_root);
    taken[gen_root] = 1'b1;
    for (int k = 1; k < n_nodes; k++) begin
      do s = $urandom_range(TABLE_SIZE - 1); while (taken[s]);
      slot[k] = s;
      taken[s] = 1'b1;
    end
    for (int k = n_nodes - 1; k >= 0; k--) begin
      if (is_leaf[k]) begin
        push_load(slot[k], 1'b1, $urandom_range(255), $urandom_range(TABLE_SIZE - 1),
                  $urandom_range(TABLE_SIZE - 1));
      end else begin
        push_load(slot[k], 1'b0, $urandom_range(255), slot[lc[k]], slot[rc[k]]);
      end
    end
  endfunction

  function automatic void fill_stream(input int n);
    int target;
    int roll;
    int leaves;
    target = gen_items + n;
    while (gen_items < target) begin
      if (!gen_written[gen_root]) begin
        build_tree($urandom_range(2, 12));
      end
      roll = $urandom_range(99);
      if (roll < 30) begin
        roll = $urandom_range(99);
        if (roll < 6) begin
          leaves = 1;
        end else if (roll < 92) begin
          leaves = $urandom_range(2, 12);
        end else begin
          leaves = $urandom_range(13, 64);
        end
        build_tree(leaves);
        repeat ($urandom_range(8, 60)) push_bit(1'($urandom_range(1)));
      end else if (roll < 40) begin
        // stray node write: a leaf anywhere, or an inner node onto written nodes
        if ($urandom_range(1)) begin
          push_load($urandom_range(TABLE_SIZE - 1), 1'b1, $urandom_range(255),
                    $urandom_range(TABLE_SIZE - 1), $urandom_range(TABLE_SIZE - 1));
        end else begin
          push_load($urandom_range(TABLE_SIZE - 1), 1'b0, $urandom_range(255),
                    written_list[$urandom_range(written_list.size() - 1)],
                    written_list[$urandom_range(written_list.size() - 1)]);
        end
      end else begin
        repeat ($urandom_range(1, 40)) push_bit(1'($urandom_range(1)));
      end
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk); while (pending_cmds.size() != 0 || in_push || due_symbols.size() != 0);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_root(input logic [PORT_IDX_W-1:0] r);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= r;
    root_reg = r;
    walk_pos = r;
    gen_root = r;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      drv_busy = in_push;
      if (in_push && !in_full) begin
        decode_walk(drv_cmd);
        drv_busy = 1'b0;
      end
      if (!drv_busy && pending_cmds.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        drv_cmd = pending_cmds.pop_front();
        in_func        <= drv_cmd.func;
        in_node_index  <= drv_cmd.node_index;
        in_node_leaf   <= drv_cmd.leaf;
        in_node_symbol <= drv_cmd.sym;
        in_left_child  <= drv_cmd.left;
        in_right_child <= drv_cmd.right;
        in_code_bit    <= drv_cmd.code_bit;
        drv_busy = 1'b1;
      end
      in_push <= drv_busy;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        rx_got++;
        if (due_symbols.size() == 0) begin
          err_count++;
          $display("%0t: out_symbol transfer with none due: expected none, actual %02h",
                   $time, out_symbol);
        end else begin
          exp_sym = due_symbols.pop_front();
          if (out_symbol !== exp_sym) begin
            err_count++;
            $display("%0t: out_symbol mismatch: expected %02h, actual %02h",
                     $time, exp_sym, out_symbol);
          end
        end
      end
      // long hold-off so the decoder backs up and raises in_full
      if (hold_left > 0) begin
        hold_left--;
      end else if (phase_no == 1 && !hold_done && rx_got >= 40) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      out_pop <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: small tree at the reset root 0
    push_load(85, 1'b1, 8'hFF, 0, 511);
    push_load(256, 1'b1, 8'h5A, 511, 0);
    push_load(511, 1'b1, 8'h00, 170, 85);
    push_load(170, 1'b0, 8'h81, 85, 256);
    push_load(0, 1'b0, 8'h7E, 511, 170);
    push_bit(1'b0);
    push_bit(1'b1);
    push_bit(1'b0);
    push_bit(1'b1);
    push_bit(1'b1);
    // partial code cut short by a node write
    push_bit(1'b1);
    push_load(256, 1'b1, 8'hA5, 511, 0);
    push_bit(1'b1);
    push_bit(1'b1);
    // root as a leaf
    push_load(0, 1'b1, 8'h3C, 511, 170);
    push_bit(1'b0);
    push_bit(1'b1);
    push_load(0, 1'b0, 8'h7E, 511, 170);
    push_bit(1'b0);
    wait_drained();

    phase_no = 1;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    write_root(PORT_IDX_W'(511));
    fill_stream(400);
    wait_drained();

    phase_no = 2;
    tx_idle_pct = 84;
    rx_stall_pct = 0;
    write_root(PORT_IDX_W'($urandom_range(TABLE_SIZE - 1)));
    fill_stream(300);
    wait_drained();

    phase_no = 3;
    tx_idle_pct = 0;
    rx_stall_pct = 84;
    write_root('0);
    fill_stream(350);
    wait_drained();

    phase_no = 4;
    tx_idle_pct = 30;
    rx_stall_pct = 30;
    write_root(PORT_IDX_W'($urandom_range(TABLE_SIZE - 1)));
    fill_stream(225);
    // sender pauses here until every due symbol has come back
    wait_drained();
    fill_stream(225);
    wait_drained();

    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
